/* src/fptw_pkg.sv */
// Shared types and constants for the FM PLL tuning I2C writer.
package fptw_pkg;

   localparam int FREQ_W       = 16;
   localparam int POWER_W      = 8;
   localparam int BYTE_W       = 8;
   localparam int TICKS_W      = 16;
   localparam int VALUE_W      = 17;
   localparam int CSR_INDEX_W  = 3;
   localparam int CSR_DATA_W   = 16;
   localparam int BIT_INDEX_W  = 4;
   localparam int BYTE_INDEX_W = 3;

   localparam logic [BYTE_W-1:0]       CONTROL_BYTE   = 8'd192;
   localparam logic [BIT_INDEX_W-1:0]  BITS_PER_BYTE  = 4'd8;
   localparam logic [BYTE_INDEX_W-1:0] LAST_BYTE      = 3'd4;

   localparam logic [FREQ_W-1:0]  FREQ_LOW_RESET     = 16'd1750;
   localparam logic [FREQ_W-1:0]  FREQ_HIGH_RESET    = 16'd2160;
   localparam logic [FREQ_W-1:0]  FREQ_FALLBACK_RESET = 16'd1750;
   localparam logic [POWER_W-1:0] POWER_LOW_RESET    = 8'd0;
   localparam logic [POWER_W-1:0] POWER_HIGH_RESET   = 8'd255;
   localparam logic [BYTE_W-1:0]  ADDRESS_RESET      = 8'd0;
   localparam logic [TICKS_W-1:0] PHASE_TICKS_RESET  = 16'd1;

   typedef enum logic [1:0] {
      MODE_TICK   = 2'd0,
      MODE_FREQ   = 2'd1,
      MODE_POWER  = 2'd2,
      MODE_STEREO = 2'd3
   } mode_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FREQ_LOW      = 3'd0,
      CSR_FREQ_HIGH     = 3'd1,
      CSR_FREQ_FALLBACK = 3'd2,
      CSR_POWER_LOW     = 3'd3,
      CSR_POWER_HIGH    = 3'd4,
      CSR_ADDRESS       = 3'd5,
      CSR_PHASE_TICKS   = 3'd6,
      CSR_INVERT_STEREO = 3'd7
   } csr_index_type;

   typedef enum logic [9:0] {
      PH_IDLE      = 10'b00_0000_0001,
      PH_LEAD      = 10'b00_0000_0010,
      PH_SDA_FALL  = 10'b00_0000_0100,
      PH_SCL_FALL  = 10'b00_0000_1000,
      PH_FIRST_BIT = 10'b00_0001_0000,
      PH_SCL_RISE  = 10'b00_0010_0000,
      PH_SCL_LOW   = 10'b00_0100_0000,
      PH_NEXT_BIT  = 10'b00_1000_0000,
      PH_STOP_SCL  = 10'b01_0000_0000,
      PH_STOP_SDA  = 10'b10_0000_0000
   } phase_type;

   typedef struct packed {
      logic               scl_pin;
      logic               sda_pin;
      logic               mono_pin;
      logic               busy_res;
      logic               rejected;
      logic [FREQ_W-1:0]  freq_now;
      logic [POWER_W-1:0] power_now;
   } rsp_type;

endpackage

/* src/fptw_if.sv */
// Valid/ready channel interfaces for the request, response and register write ports.
interface fptw_req_if;
   logic                                   valid;
   logic                                   ready;
   logic [1:0]                             mode;
   logic signed [fptw_pkg::VALUE_W-1:0]    value;
   logic                                   value_absent;

   modport source (output valid, mode, value, value_absent, input ready);
   modport sink (input valid, mode, value, value_absent, output ready);
endinterface

interface fptw_rsp_if;
   logic                            valid;
   logic                            ready;
   logic                            scl_pin;
   logic                            sda_pin;
   logic                            mono_pin;
   logic                            busy_res;
   logic                            rejected;
   logic [fptw_pkg::FREQ_W-1:0]     freq_now;
   logic [fptw_pkg::POWER_W-1:0]    power_now;

   modport source (output valid, scl_pin, sda_pin, mono_pin, busy_res, rejected,
                   freq_now, power_now, input ready);
   modport sink (input valid, scl_pin, sda_pin, mono_pin, busy_res, rejected,
                 freq_now, power_now, output ready);
endinterface

interface fptw_csr_if;
   logic                                valid;
   logic                                ready;
   logic [fptw_pkg::CSR_INDEX_W-1:0]    index;
   logic [fptw_pkg::CSR_DATA_W-1:0]     data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

/* src/fm_pll_tuning_i2c_writer_top.sv */
// Top level of the FM PLL tuning I2C writer: command handling and bit-banged write sequencer.
// The result of an item is registered into the output entry, or into the skid entry while the output is stalled.
// Throughput: one item per cycle while the skid entry is empty, set by the single state update between the request
// port and the two-entry response buffer; a new item is taken while one result waits.
// Reset: synchronous, active high; clears the sequencer, pins and stored values, and
// loads the register defaults. No clearing pass is needed.
module fm_pll_tuning_i2c_writer_top (
   input logic         clock,
   input logic         reset,
   fptw_req_if.sink    req_chan,
   fptw_rsp_if.source  rsp_chan,
   fptw_csr_if.sink    csr_chan
);

   function automatic logic [fptw_pkg::FREQ_W-1:0] clamp_freq(
      input logic signed [fptw_pkg::VALUE_W-1:0] v,
      input logic [fptw_pkg::FREQ_W-1:0]         lo,
      input logic [fptw_pkg::FREQ_W-1:0]         hi);
      logic signed [fptw_pkg::VALUE_W:0] v_ext;
      v_ext = {v[fptw_pkg::VALUE_W-1], v};
      if (v_ext < $signed({2'b00, lo})) begin
         return lo;
      end else if (v_ext > $signed({2'b00, hi})) begin
         return hi;
      end else begin
         return v[fptw_pkg::FREQ_W-1:0];
      end
   endfunction

   function automatic logic [fptw_pkg::POWER_W-1:0] clamp_power(
      input logic signed [fptw_pkg::VALUE_W-1:0] v,
      input logic [fptw_pkg::POWER_W-1:0]        lo,
      input logic [fptw_pkg::POWER_W-1:0]        hi);
      logic signed [fptw_pkg::VALUE_W:0] v_ext;
      v_ext = {v[fptw_pkg::VALUE_W-1], v};
      if (v_ext < $signed({10'b0, lo})) begin
         return lo;
      end else if (v_ext > $signed({10'b0, hi})) begin
         return hi;
      end else begin
         return v[fptw_pkg::POWER_W-1:0];
      end
   endfunction

   // Register settings.
   logic [fptw_pkg::FREQ_W-1:0]  freq_low_ff, freq_high_ff, freq_fallback_ff;
   logic [fptw_pkg::POWER_W-1:0] power_low_ff, power_high_ff;
   logic [fptw_pkg::BYTE_W-1:0]  address_ff;
   logic [fptw_pkg::TICKS_W-1:0] phase_ticks_ff;
   logic                         invert_stereo_ff;

   // Block state.
   logic [fptw_pkg::FREQ_W-1:0]       freq_ff, freq_in;
   logic [fptw_pkg::POWER_W-1:0]      power_ff, power_in;
   logic                              freq_known_ff, freq_known_in;
   logic                              power_known_ff, power_known_in;
   logic [fptw_pkg::BYTE_W-1:0]       shift_ff, shift_in;
   logic [fptw_pkg::BIT_INDEX_W-1:0]  bit_index_ff, bit_index_in;
   logic [fptw_pkg::BYTE_INDEX_W-1:0] byte_index_ff, byte_index_in;
   fptw_pkg::phase_type               phase_ff, phase_in;
   logic [fptw_pkg::TICKS_W-1:0]      delay_ff, delay_in;
   logic                              scl_ff, scl_in;
   logic                              sda_ff, sda_in;
   logic                              mono_ff, mono_in;

   // Response buffer.
   fptw_pkg::rsp_type out_ff, out_in, skid_ff, skid_in, result;
   logic              out_valid_ff, out_valid_in, skid_valid_ff, skid_valid_in;

   logic                         req_accept;
   logic                         busy;
   logic                         rejected;
   logic [fptw_pkg::TICKS_W-1:0] delay_load;
   logic [fptw_pkg::BIT_INDEX_W-1:0] bit_next;
   logic [fptw_pkg::BYTE_W-1:0]  shift_next;
   logic [fptw_pkg::BYTE_INDEX_W-1:0] byte_next;
   logic [fptw_pkg::BYTE_W-1:0]  byte_load;

   assign csr_chan.ready = 1'b1;
   assign req_chan.ready = !skid_valid_ff;
   assign req_accept     = req_chan.valid && req_chan.ready;
   assign busy           = phase_ff != fptw_pkg::PH_IDLE;
   assign delay_load     = (phase_ticks_ff == '0) ? fptw_pkg::TICKS_W'(1) : phase_ticks_ff;
   assign bit_next       = bit_index_ff + 1'b1;
   assign shift_next     = {shift_ff[fptw_pkg::BYTE_W-2:0], 1'b0};
   assign byte_next      = byte_index_ff + 1'b1;

   always_comb begin
      case (byte_next)
         3'd1:    byte_load = freq_ff[15:8];
         3'd2:    byte_load = freq_ff[7:0];
         3'd3:    byte_load = fptw_pkg::CONTROL_BYTE;
         default: byte_load = power_ff;
      endcase
   end

   always_comb begin
      freq_in        = freq_ff;
      power_in       = power_ff;
      freq_known_in  = freq_known_ff;
      power_known_in = power_known_ff;
      shift_in       = shift_ff;
      bit_index_in   = bit_index_ff;
      byte_index_in  = byte_index_ff;
      phase_in       = phase_ff;
      delay_in       = delay_ff;
      scl_in         = scl_ff;
      sda_in         = sda_ff;
      mono_in        = mono_ff;
      rejected       = 1'b0;
      if (req_accept) begin
         if (fptw_pkg::mode_type'(req_chan.mode) == fptw_pkg::MODE_TICK) begin
            if (busy) begin
               if (delay_ff > fptw_pkg::TICKS_W'(1)) begin
                  delay_in = delay_ff - 1'b1;
               end else begin
                  delay_in = delay_load;
                  case (phase_ff)
                     fptw_pkg::PH_LEAD: begin
                        sda_in   = 1'b1;
                        scl_in   = 1'b1;
                        phase_in = fptw_pkg::PH_SDA_FALL;
                     end
                     fptw_pkg::PH_SDA_FALL: begin
                        sda_in   = 1'b0;
                        phase_in = fptw_pkg::PH_SCL_FALL;
                     end
                     fptw_pkg::PH_SCL_FALL: begin
                        scl_in   = 1'b0;
                        phase_in = fptw_pkg::PH_FIRST_BIT;
                     end
                     fptw_pkg::PH_FIRST_BIT: begin
                        byte_index_in = '0;
                        bit_index_in  = '0;
                        shift_in      = address_ff;
                        sda_in        = address_ff[fptw_pkg::BYTE_W-1];
                        phase_in      = fptw_pkg::PH_SCL_RISE;
                     end
                     fptw_pkg::PH_SCL_RISE: begin
                        scl_in   = 1'b1;
                        phase_in = fptw_pkg::PH_SCL_LOW;
                     end
                     fptw_pkg::PH_SCL_LOW: begin
                        scl_in   = 1'b0;
                        phase_in = fptw_pkg::PH_NEXT_BIT;
                     end
                     fptw_pkg::PH_NEXT_BIT: begin
                        if (bit_index_ff < fptw_pkg::BITS_PER_BYTE) begin
                           // After the eighth bit the data line is released for the ack slot.
                           bit_index_in = bit_next;
                           shift_in     = shift_next;
                           sda_in       = (bit_next < fptw_pkg::BITS_PER_BYTE) ?
                                          shift_next[fptw_pkg::BYTE_W-1] : 1'b1;
                           phase_in     = fptw_pkg::PH_SCL_RISE;
                        end else if (byte_index_ff < fptw_pkg::LAST_BYTE) begin
                           byte_index_in = byte_next;
                           bit_index_in  = '0;
                           shift_in      = byte_load;
                           sda_in        = byte_load[fptw_pkg::BYTE_W-1];
                           phase_in      = fptw_pkg::PH_SCL_RISE;
                        end else begin
                           sda_in   = 1'b0;
                           phase_in = fptw_pkg::PH_STOP_SCL;
                        end
                     end
                     fptw_pkg::PH_STOP_SCL: begin
                        scl_in   = 1'b1;
                        phase_in = fptw_pkg::PH_STOP_SDA;
                     end
                     default: begin
                        sda_in   = 1'b1;
                        phase_in = fptw_pkg::PH_IDLE;
                        delay_in = '0;
                     end
                  endcase
               end
            end
         end else if (busy) begin
            rejected = 1'b1;
         end else if (fptw_pkg::mode_type'(req_chan.mode) == fptw_pkg::MODE_STEREO) begin
            mono_in = !((req_chan.value != '0) != invert_stereo_ff);
         end else begin
            if (fptw_pkg::mode_type'(req_chan.mode) == fptw_pkg::MODE_FREQ) begin
               freq_in  = req_chan.value_absent ? freq_fallback_ff :
                          clamp_freq(req_chan.value, freq_low_ff, freq_high_ff);
               if (!power_known_ff || power_ff < power_low_ff) begin
                  power_in = power_low_ff;
               end else if (power_ff > power_high_ff) begin
                  power_in = power_high_ff;
               end
            end else begin
               if (!freq_known_ff) begin
                  freq_in = freq_fallback_ff;
               end else if (freq_ff < freq_low_ff) begin
                  freq_in = freq_low_ff;
               end else if (freq_ff > freq_high_ff) begin
                  freq_in = freq_high_ff;
               end
               power_in = req_chan.value_absent ? power_low_ff :
                          clamp_power(req_chan.value, power_low_ff, power_high_ff);
            end
            freq_known_in  = 1'b1;
            power_known_in = 1'b1;
            byte_index_in  = '0;
            bit_index_in   = '0;
            shift_in       = address_ff;
            phase_in       = fptw_pkg::PH_LEAD;
            delay_in       = delay_load;
         end
      end
   end

   always_comb begin
      result.scl_pin   = scl_in;
      result.sda_pin   = sda_in;
      result.mono_pin  = mono_in;
      result.busy_res  = phase_in != fptw_pkg::PH_IDLE;
      result.rejected  = rejected;
      result.freq_now  = freq_in;
      result.power_now = power_in;
   end

   // The skid entry holds a result taken while the output entry is stalled.
   always_comb begin
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (out_valid_ff && rsp_chan.ready) begin
         out_valid_in  = skid_valid_ff;
         out_in        = skid_ff;
         skid_valid_in = 1'b0;
      end
      if (req_accept) begin
         if (!out_valid_ff || rsp_chan.ready) begin
            out_in       = result;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = result;
            skid_valid_in = 1'b1;
         end
      end
   end

   assign rsp_chan.valid     = out_valid_ff;
   assign rsp_chan.scl_pin   = out_ff.scl_pin;
   assign rsp_chan.sda_pin   = out_ff.sda_pin;
   assign rsp_chan.mono_pin  = out_ff.mono_pin;
   assign rsp_chan.busy_res  = out_ff.busy_res;
   assign rsp_chan.rejected  = out_ff.rejected;
   assign rsp_chan.freq_now  = out_ff.freq_now;
   assign rsp_chan.power_now = out_ff.power_now;

   always_ff @(posedge clock) begin
      if (reset) begin
         freq_low_ff      <= fptw_pkg::FREQ_LOW_RESET;
         freq_high_ff     <= fptw_pkg::FREQ_HIGH_RESET;
         freq_fallback_ff <= fptw_pkg::FREQ_FALLBACK_RESET;
         power_low_ff     <= fptw_pkg::POWER_LOW_RESET;
         power_high_ff    <= fptw_pkg::POWER_HIGH_RESET;
         address_ff       <= fptw_pkg::ADDRESS_RESET;
         phase_ticks_ff   <= fptw_pkg::PHASE_TICKS_RESET;
         invert_stereo_ff <= 1'b0;
      end else if (csr_chan.valid && csr_chan.ready) begin
         case (fptw_pkg::csr_index_type'(csr_chan.index))
            fptw_pkg::CSR_FREQ_LOW:      freq_low_ff      <= csr_chan.data;
            fptw_pkg::CSR_FREQ_HIGH:     freq_high_ff     <= csr_chan.data;
            fptw_pkg::CSR_FREQ_FALLBACK: freq_fallback_ff <= csr_chan.data;
            fptw_pkg::CSR_POWER_LOW:     power_low_ff     <= csr_chan.data[7:0];
            fptw_pkg::CSR_POWER_HIGH:    power_high_ff    <= csr_chan.data[7:0];
            fptw_pkg::CSR_ADDRESS:       address_ff       <= csr_chan.data[7:0];
            fptw_pkg::CSR_PHASE_TICKS:   phase_ticks_ff   <= csr_chan.data;
            default:                     invert_stereo_ff <= csr_chan.data[0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         freq_ff        <= '0;
         power_ff       <= '0;
         freq_known_ff  <= 1'b0;
         power_known_ff <= 1'b0;
         shift_ff       <= '0;
         bit_index_ff   <= '0;
         byte_index_ff  <= '0;
         phase_ff       <= fptw_pkg::PH_IDLE;
         delay_ff       <= '0;
         scl_ff         <= 1'b0;
         sda_ff         <= 1'b0;
         mono_ff        <= 1'b0;
         out_valid_ff   <= 1'b0;
         skid_valid_ff  <= 1'b0;
      end else begin
         freq_ff        <= freq_in;
         power_ff       <= power_in;
         freq_known_ff  <= freq_known_in;
         power_known_ff <= power_known_in;
         shift_ff       <= shift_in;
         bit_index_ff   <= bit_index_in;
         byte_index_ff  <= byte_index_in;
         phase_ff       <= phase_in;
         delay_ff       <= delay_in;
         scl_ff         <= scl_in;
         sda_ff         <= sda_in;
         mono_ff        <= mono_in;
         out_valid_ff   <= out_valid_in;
         skid_valid_ff  <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

endmodule
